// ===== hw/rtl/dsc_pkg.sv =====
// ----------------------------------------------------------------------------
// dsc_pkg
// shared widths, register indexes and transaction types of the segment
// coalescer
// ----------------------------------------------------------------------------
`default_nettype none

package dsc_pkg;

   localparam int ADDR_W     = 64;
   localparam int SEG_LEN_W  = 32;
   localparam int BYTES_W    = 40;
   localparam int RANGE_W    = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 40;

   // default depth of the command queue between front and back
   localparam int CMD_QUEUE_DEPTH = 4;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_START_OFFSET = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_LENGTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_RANGES   = 2'd2;

   typedef struct packed {
      logic [ADDR_W-1:0]    seg_addr;
      logic [SEG_LEN_W-1:0] seg_len;
      logic                 seg_last;
   } req_type;

   typedef struct packed {
      logic                 range_present;
      logic [ADDR_W-1:0]    range_addr;
      logic [BYTES_W-1:0]   range_len;
      logic [RANGE_W-1:0]   range_index;
      logic                 range_kept;
      logic                 list_done;
      logic [RANGE_W-1:0]   range_total;
   } rsp_type;

   // one classified segment: the run it closes, the run that holds it
   typedef struct packed {
      logic                 close_prev;
      logic [ADDR_W-1:0]    prev_start;
      logic [BYTES_W-1:0]   prev_bytes;
      logic [ADDR_W-1:0]    cur_start;
      logic [BYTES_W-1:0]   cur_bytes;
      logic                 last;
   } cmd_type;

   // one closed run after offset skipping
   typedef struct packed {
      logic                 survived;
      logic [ADDR_W-1:0]    addr;
      logic [BYTES_W-1:0]   len;
      logic                 is_end;
   } tok_type;

   typedef struct packed {
      logic [BYTES_W-1:0]   start_offset;
      logic [BYTES_W-1:0]   total_length;
      logic [RANGE_W-1:0]   max_ranges;
   } cfg_type;

endpackage

`default_nettype wire

// ===== hw/rtl/dsc_front.sv =====
// ----------------------------------------------------------------------------
// dsc_front
// takes segment transactions, tracks the open run and classifies each
// segment into a close command for the back end
// ----------------------------------------------------------------------------
`default_nettype none

module dsc_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire dsc_pkg::req_type req_data,
   input  wire logic             q_full,
   output logic                  cmd_write,
   output dsc_pkg::cmd_type      cmd_data
);
   import dsc_pkg::*;

   logic [ADDR_W-1:0]  run_start_ff, run_start_in;
   logic [BYTES_W-1:0] run_bytes_ff, run_bytes_in;
   logic               run_open_ff, run_open_in;

   logic               accept;
   logic [ADDR_W-1:0]  run_end;
   logic               contig;
   logic [BYTES_W:0]   bytes_sum;
   logic [BYTES_W-1:0] merged_bytes;
   logic [ADDR_W-1:0]  cur_start;
   logic [BYTES_W-1:0] cur_bytes;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   assign run_end = run_start_ff + {{(ADDR_W-BYTES_W){1'b0}}, run_bytes_ff};
   assign contig  = run_open_ff && (req_data.seg_addr == run_end);

   // run length saturates at the field maximum
   assign bytes_sum    = {1'b0, run_bytes_ff} + (BYTES_W+1)'(req_data.seg_len);
   assign merged_bytes = bytes_sum[BYTES_W] ? '1 : bytes_sum[BYTES_W-1:0];

   assign cur_start = contig ? run_start_ff : req_data.seg_addr;
   assign cur_bytes = contig ? merged_bytes : BYTES_W'(req_data.seg_len);

   always_comb begin
      cmd_data.close_prev = run_open_ff && !contig;
      cmd_data.prev_start = run_start_ff;
      cmd_data.prev_bytes = run_bytes_ff;
      cmd_data.cur_start  = cur_start;
      cmd_data.cur_bytes  = cur_bytes;
      cmd_data.last       = req_data.seg_last;
   end

   // plain merges carry no work for the back end
   assign cmd_write = accept && (cmd_data.close_prev || req_data.seg_last);

   always_comb begin
      run_open_in  = run_open_ff;
      run_start_in = run_start_ff;
      run_bytes_in = run_bytes_ff;
      if (accept) begin
         run_open_in  = !req_data.seg_last;
         run_start_in = cur_start;
         run_bytes_in = cur_bytes;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_open_ff <= 1'b0;
      end else begin
         run_open_ff <= run_open_in;
      end
      run_start_ff <= run_start_in;
      run_bytes_ff <= run_bytes_in;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/dsc_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// dsc_cmd_queue
// short first-in first-out queue of close commands between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module dsc_cmd_queue #(
   parameter int DEPTH = dsc_pkg::CMD_QUEUE_DEPTH   // 2 or more
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr,
   input  wire dsc_pkg::cmd_type wr_data,
   output logic                  full,
   input  wire logic             rd,
   output dsc_pkg::cmd_type      rd_data,
   output logic                  empty
);
   import dsc_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_wr, do_rd;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign rd_data = mem_ff[rd_ptr_ff];
   assign do_wr   = wr && !full;
   assign do_rd   = rd && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("command queue count beyond depth");

endmodule

`default_nettype wire

// ===== hw/rtl/dsc_trim.sv =====
// ----------------------------------------------------------------------------
// dsc_trim
// first back-end stage: walks the closes of each command and applies the
// start offset skip
// ----------------------------------------------------------------------------
`default_nettype none

module dsc_trim (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         q_empty,
   input  wire dsc_pkg::cmd_type             head,
   output logic                              q_pop,
   input  wire logic [dsc_pkg::BYTES_W-1:0]  start_offset,
   input  wire logic                         skip_load,
   input  wire logic                         tok_take,
   output logic                              tok_valid,
   output dsc_pkg::tok_type                  tok_data
);
   import dsc_pkg::*;

   logic               phase_ff, phase_in;
   logic [BYTES_W-1:0] skip_left_ff, skip_left_in;
   logic               tok_valid_ff, tok_valid_in;
   tok_type            tok_ff, tok_in;

   logic               use_prev;
   logic [ADDR_W-1:0]  sel_start;
   logic [BYTES_W-1:0] sel_bytes;
   logic               work;
   logic               swallow;

   // phase set: the previous run is closed, the final run still to go
   assign use_prev  = !phase_ff && head.close_prev;
   assign sel_start = use_prev ? head.prev_start : head.cur_start;
   assign sel_bytes = use_prev ? head.prev_bytes : head.cur_bytes;
   assign work      = !q_empty && (!tok_valid_ff || tok_take);
   assign q_pop     = work && !(use_prev && head.last);
   assign swallow   = (sel_bytes <= skip_left_ff);

   always_comb begin
      phase_in     = phase_ff;
      skip_left_in = skip_left_ff;
      tok_valid_in = tok_valid_ff;
      tok_in       = tok_ff;
      if (work) begin
         phase_in        = use_prev && head.last;
         tok_valid_in    = 1'b1;
         tok_in.survived = !swallow;
         tok_in.addr     = sel_start + {{(ADDR_W-BYTES_W){1'b0}}, skip_left_ff};
         tok_in.len      = sel_bytes - skip_left_ff;
         tok_in.is_end   = !use_prev;
         if (!use_prev) begin
            skip_left_in = start_offset;
         end else if (swallow) begin
            skip_left_in = skip_left_ff - sel_bytes;
         end else begin
            skip_left_in = '0;
         end
      end else if (tok_take) begin
         tok_valid_in = 1'b0;
      end
      if (skip_load) begin
         skip_left_in = start_offset;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= 1'b0;
         skip_left_ff <= '0;
         tok_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         skip_left_ff <= skip_left_in;
         tok_valid_ff <= tok_valid_in;
      end
      tok_ff <= tok_in;
   end

   assign tok_valid = tok_valid_ff;
   assign tok_data  = tok_ff;

   a_phase_head: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> (!q_empty && head.last))
      else $error("second close pending without a last command at the head");

endmodule

`default_nettype wire

// ===== hw/rtl/dsc_emit.sv =====
// ----------------------------------------------------------------------------
// dsc_emit
// second back-end stage: clips runs to the total length, numbers them and
// drives the result register
// ----------------------------------------------------------------------------
`default_nettype none

module dsc_emit (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         tok_valid,
   input  wire dsc_pkg::tok_type             tok_data,
   output logic                              tok_take,
   input  wire logic [dsc_pkg::BYTES_W-1:0]  total_length,
   input  wire logic [dsc_pkg::RANGE_W-1:0]  max_ranges,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output dsc_pkg::rsp_type                  rsp_data
);
   import dsc_pkg::*;

   logic [BYTES_W-1:0] bytes_done_ff, bytes_done_in;
   logic [RANGE_W-1:0] range_count_ff, range_count_in;
   logic               fin_ff, fin_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               out_free;
   logic               emit_range, emit_bare;
   logic               over;
   logic [BYTES_W-1:0] remain;
   logic [BYTES_W-1:0] clip_len;
   logic               fin_next;
   logic [BYTES_W-1:0] done_next;
   logic [RANGE_W-1:0] count_next;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign tok_take = tok_valid && out_free;

   assign emit_range = !fin_ff && tok_data.survived;
   assign emit_bare  = !fin_ff && !tok_data.survived && tok_data.is_end;

   // clip against what is left of the total
   assign over       = (bytes_done_ff >= total_length);
   assign remain     = total_length - bytes_done_ff;
   assign fin_next   = over || (tok_data.len >= remain);
   assign clip_len   = over ? '0 : ((tok_data.len > remain) ? remain : tok_data.len);
   assign done_next  = fin_next ? total_length : bytes_done_ff + tok_data.len;
   assign count_next = (range_count_ff == '1) ? range_count_ff
                                              : range_count_ff + 1'b1;

   always_comb begin
      bytes_done_in  = bytes_done_ff;
      range_count_in = range_count_ff;
      fin_in         = fin_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;
      if (out_free) begin
         rsp_valid_in = tok_take && (emit_range || emit_bare);
      end
      if (tok_take) begin
         if (emit_range) begin
            rsp_data_in.range_present = 1'b1;
            rsp_data_in.range_addr    = tok_data.addr;
            rsp_data_in.range_len     = clip_len;
            rsp_data_in.range_index   = range_count_ff;
            rsp_data_in.range_kept    = (range_count_ff < max_ranges);
            rsp_data_in.list_done     = fin_next || tok_data.is_end;
            rsp_data_in.range_total   = count_next;
         end else begin
            rsp_data_in.range_present = 1'b0;
            rsp_data_in.range_addr    = '0;
            rsp_data_in.range_len     = '0;
            rsp_data_in.range_index   = '0;
            rsp_data_in.range_kept    = 1'b0;
            rsp_data_in.list_done     = 1'b1;
            rsp_data_in.range_total   = range_count_ff;
         end
         if (tok_data.is_end) begin
            bytes_done_in  = '0;
            range_count_in = '0;
            fin_in         = 1'b0;
         end else if (emit_range) begin
            bytes_done_in  = done_next;
            range_count_in = count_next;
            fin_in         = fin_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_done_ff  <= '0;
         range_count_ff <= '0;
         fin_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         bytes_done_ff  <= bytes_done_in;
         range_count_ff <= range_count_in;
         fin_ff         <= fin_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_rearm: assert property (@(posedge clock) disable iff (reset)
      (tok_take && tok_data.is_end) |=> (range_count_ff == '0 && !fin_ff))
      else $error("list end did not clear the range state");

   a_bare_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.range_present) |-> rsp_data_ff.list_done)
      else $error("bare completion without list done");

endmodule

`default_nettype wire

// ===== hw/rtl/dma_segment_coalescer.sv =====
// ----------------------------------------------------------------------------
// dma_segment_coalescer
// merges contiguous DMA segments into ranges, skips a start offset, clips
// to a total length and numbers the ranges of each list
// ----------------------------------------------------------------------------
// path: a range reaches rsp_valid through the queue write, the trim register
//   and the emit register once the segment that closes it is accepted; the
//   second range of a segment that also ends its list follows it out of trim
// throughput: one segment per cycle while the queue is not full; a segment that
//   both closes the previous run and is the last of its list holds trim for both ranges
// reset: synchronous, active high; clears all lists, the queue and the
//   configuration registers (offset, length and capacity read as zero)
// ----------------------------------------------------------------------------
`default_nettype none

module dma_segment_coalescer #(
   parameter int CMD_DEPTH = dsc_pkg::CMD_QUEUE_DEPTH   // command queue slots, 2 or more
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // segment transactions
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire dsc_pkg::req_type                 req_data,
   // range transactions
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output dsc_pkg::rsp_type                      rsp_data,
   // register writes
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [dsc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [dsc_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import dsc_pkg::*;

   // configuration registers
   cfg_type  cfg_ff, cfg_in;
   logic     csr_write;
   logic     skip_load;

   // front to queue
   logic     cmd_write;
   cmd_type  cmd_data;
   logic     q_full;

   // queue to trim
   cmd_type  q_head;
   logic     q_empty;
   logic     q_pop;

   // trim to emit
   logic     tok_valid;
   tok_type  tok_data;
   logic     tok_take;

   // register writes never wait
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      cfg_in    = cfg_ff;
      skip_load = 1'b0;
      if (csr_write) begin
         unique case (csr_index)
            CSR_START_OFFSET: begin
               cfg_in.start_offset = csr_wdata[BYTES_W-1:0];
               // an offset write also reloads the running skip count
               skip_load           = 1'b1;
            end
            CSR_TOTAL_LENGTH: begin
               cfg_in.total_length = csr_wdata[BYTES_W-1:0];
            end
            CSR_MAX_RANGES: begin
               cfg_in.max_ranges   = csr_wdata[RANGE_W-1:0];
            end
            default: begin
               // unused index, write dropped
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: contiguity check and run tracking, one segment per cycle while the queue has room
   dsc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .cmd_write (cmd_write),
      .cmd_data  (cmd_data)
   );

   // queue lets the front keep taking segments while the back end waits
   dsc_cmd_queue #(
      .DEPTH (CMD_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr      (cmd_write),
      .wr_data (cmd_data),
      .full    (q_full),
      .rd      (q_pop),
      .rd_data (q_head),
      .empty   (q_empty)
   );

   // back end, stage one: offset skip per closed run
   // offset taken from the write path so a new offset reloads the skip at once
   dsc_trim u_trim (
      .clock        (clock),
      .reset        (reset),
      .q_empty      (q_empty),
      .head         (q_head),
      .q_pop        (q_pop),
      .start_offset (cfg_in.start_offset),
      .skip_load    (skip_load),
      .tok_take     (tok_take),
      .tok_valid    (tok_valid),
      .tok_data     (tok_data)
   );

   // back end, stage two: length clip, numbering, output register
   dsc_emit u_emit (
      .clock        (clock),
      .reset        (reset),
      .tok_valid    (tok_valid),
      .tok_data     (tok_data),
      .tok_take     (tok_take),
      .total_length (cfg_ff.total_length),
      .max_ranges   (cfg_ff.max_ranges),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data)
   );

endmodule

`default_nettype wire
